@@ rtl/pte_pkg.sv @@
package pte_pkg;

  localparam int TABLE_SLOTS_DEF = 8;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [7:0] PKT_LIGHT_UPDATE = 8'd0;
  localparam logic [7:0] PKT_RESET_SWARM  = 8'd1;
  localparam logic [7:0] PKT_SERVER       = 8'd2;
  localparam logic [7:0] PKT_RESET_ME     = 8'd3;
  localparam logic [7:0] PKT_BLINK        = 8'd4;
  localparam logic [7:0] PKT_LOG          = 8'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ID_SCAN,
    ST_TIME_SCAN,
    ST_WRITE,
    ST_ELECT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  id;
    logic [15:0] light;
    logic [31:0] stamp;
  } tbl_wr_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] light;
    logic [31:0] stamp;
  } tbl_rd_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

@@ rtl/pte_cmp.sv @@
module pte_cmp (
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  output pte_pkg::cmp_t res
);

  assign res.eq = (a == b);
  assign res.lt = (a < b);

endmodule

@@ rtl/pte_table.sv @@
module pte_table #(
  parameter int TABLE_SLOTS = pte_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
  output pte_pkg::tbl_rd_t               rd,
  input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
  input  pte_pkg::tbl_wr_t               wr
);

  logic [7:0]  id_mem    [TABLE_SLOTS];
  logic [15:0] light_mem [TABLE_SLOTS];
  logic [31:0] stamp_mem [TABLE_SLOTS];
  logic        vld       [TABLE_SLOTS];

  logic        rd_vld;
  logic [7:0]  rd_id;
  logic [15:0] rd_light;
  logic [31:0] rd_stamp;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      id_mem[wr_addr]    <= wr.id;
      light_mem[wr_addr] <= wr.light;
      stamp_mem[wr_addr] <= wr.stamp;
    end
    rd_id    <= id_mem[rd_addr];
    rd_light <= light_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        vld[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  assign rd.id    = rd_vld ? rd_id : 8'd0;
  assign rd.light = rd_vld ? rd_light : 16'd0;
  assign rd.stamp = rd_stamp;

endmodule

@@ rtl/peer_table_leader_election.sv @@
// Channel   Direction  Signals                          Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser packet or local light sample
// m_*       out        m_tvalid m_tready m_tdata         one result word per input word
// cfg_*     in         cfg_wr_en cfg_wr_data             own_id register
//
// Samples and non-update packets go straight to the result. A light update from a peer
// runs an id scan, a time scan when an entry is evicted, a write and an election scan;
// an own-id update skips both. The slot table's single read port sets the scan length.
// rst is synchronous; it clears every slot, sets master and needs no clearing pass.
// s_tready is high only while idle; a result waiting on m_tready holds the sequencer
// in its last state but the next word can be taken as soon as that result is loaded.
module peer_table_leader_election #(
  parameter int TABLE_SLOTS = pte_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sender_id, sender_master, sender_version, sender_light, now_ms, local_light, pad
  input  logic [87:0] s_tdata,
  // action, packet_type
  input  logic [8:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // is_master, master_changed, slot_index, slot_written, evicted, unknown_type
  output logic [7:0]  m_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam logic [IW:0]   CNT_END = TABLE_SLOTS[IW:0];
  localparam logic [IW:0]   CNT_ONE = (IW + 1)'(1);
  localparam logic [IW-1:0] IDX_ONE = IW'(1);

  logic       in_action;
  logic [7:0] in_ptype;
  logic [7:0] in_sid;
  logic [15:0] in_slight;
  logic [31:0] in_now;
  logic [9:0] in_llight;

  assign in_action = s_tuser[0];
  assign in_ptype  = s_tuser[8:1];
  assign in_sid    = s_tdata[7:0];
  assign in_slight = s_tdata[39:24];
  assign in_now    = s_tdata[71:40];
  assign in_llight = s_tdata[81:72];

  pte_pkg::state_t state, state_next;
  logic [IW:0]   cnt, cnt_next;
  logic          pend, pend_next;
  logic [IW-1:0] pidx, pidx_next;
  logic [IW-1:0] slot, slot_next;
  logic [IW-1:0] best_idx, best_idx_next;
  logic [31:0]   best_time, best_time_next;
  logic          cand, cand_next;
  logic          master_flag, master_flag_next;
  logic          prev_master, prev_master_next;
  logic [15:0]   own_light, own_light_next;
  logic [7:0]    own_id;
  logic          written, written_next;
  logic          evicted, evicted_next;
  logic          unknown, unknown_next;
  logic          m_tvalid_next;
  logic [7:0]    m_tdata_next;
  logic [7:0]    sid;
  logic [15:0]   slight;
  logic [31:0]   now;

  pte_pkg::tbl_wr_t tbl_wr;
  pte_pkg::tbl_rd_t tbl_rd;
  pte_pkg::cmp_t    cmp;
  logic [31:0]      cmp_a;
  logic [31:0]      cmp_b;
  logic [IW+2:0]    slot_ext;

  pte_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(cnt[IW-1:0]),
    .rd     (tbl_rd),
    .wr_addr(slot),
    .wr     (tbl_wr)
  );

  pte_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .res(cmp)
  );

  assign s_tready = (state == pte_pkg::ST_IDLE);
  assign slot_ext = {3'b000, slot};

  always_comb begin
    unique case (state)
      pte_pkg::ST_TIME_SCAN: begin
        cmp_a = tbl_rd.stamp;
        cmp_b = best_time;
      end
      pte_pkg::ST_ELECT: begin
        cmp_a = {16'd0, own_light};
        cmp_b = {16'd0, tbl_rd.light};
      end
      default: begin
        cmp_a = {24'd0, tbl_rd.id};
        cmp_b = {24'd0, sid};
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pend_next        = pend;
    pidx_next        = pidx;
    slot_next        = slot;
    best_idx_next    = best_idx;
    best_time_next   = best_time;
    cand_next        = cand;
    master_flag_next = master_flag;
    prev_master_next = prev_master;
    own_light_next   = own_light;
    written_next     = written;
    evicted_next     = evicted;
    unknown_next     = unknown;
    m_tvalid_next    = m_tvalid & ~m_tready;
    m_tdata_next     = m_tdata;
    tbl_wr.en        = 1'b0;
    tbl_wr.id        = sid;
    tbl_wr.light     = slight;
    tbl_wr.stamp     = now;

    unique case (state)
      pte_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          prev_master_next = master_flag;
          written_next     = 1'b0;
          evicted_next     = 1'b0;
          unknown_next     = 1'b0;
          slot_next        = '0;
          cnt_next         = CNT_ONE;
          pend_next        = 1'b0;
          state_next       = pte_pkg::ST_FINISH;
          if (in_action == pte_pkg::ACT_SAMPLE) begin
            own_light_next = {6'd0, in_llight};
          end else begin
            case (in_ptype) inside
              pte_pkg::PKT_LIGHT_UPDATE: begin
                written_next = 1'b1;
                if (in_sid == own_id) begin
                  state_next = pte_pkg::ST_WRITE;
                end else begin
                  state_next = pte_pkg::ST_ID_SCAN;
                end
              end
              pte_pkg::PKT_RESET_SWARM: begin
                master_flag_next = 1'b1;
              end
              pte_pkg::PKT_RESET_ME: begin
                if (in_sid == own_id) begin
                  master_flag_next = 1'b1;
                end
              end
              pte_pkg::PKT_SERVER, pte_pkg::PKT_BLINK, pte_pkg::PKT_LOG: begin
              end
              default: begin
                unknown_next = 1'b1;
              end
            endcase
          end
        end
      end
      pte_pkg::ST_ID_SCAN: begin
        if (pend && (cmp.eq || tbl_rd.id == 8'd0)) begin
          slot_next  = pidx;
          pend_next  = 1'b0;
          state_next = pte_pkg::ST_WRITE;
        end else if (cnt < CNT_END) begin
          pend_next = 1'b1;
          pidx_next = cnt[IW-1:0];
          cnt_next  = cnt + CNT_ONE;
        end else if (!pend) begin
          cnt_next   = CNT_ONE;
          state_next = pte_pkg::ST_TIME_SCAN;
        end else begin
          pend_next = 1'b0;
        end
      end
      pte_pkg::ST_TIME_SCAN: begin
        if (pend && (pidx == IDX_ONE || cmp.lt)) begin
          best_idx_next  = pidx;
          best_time_next = tbl_rd.stamp;
        end
        if (cnt < CNT_END) begin
          pend_next = 1'b1;
          pidx_next = cnt[IW-1:0];
          cnt_next  = cnt + CNT_ONE;
        end else if (!pend) begin
          slot_next    = best_idx;
          evicted_next = 1'b1;
          state_next   = pte_pkg::ST_WRITE;
        end else begin
          pend_next = 1'b0;
        end
      end
      pte_pkg::ST_WRITE: begin
        if (slot == '0) begin
          own_light_next = slight;
        end else begin
          tbl_wr.en = 1'b1;
        end
        cnt_next   = CNT_ONE;
        pend_next  = 1'b0;
        cand_next  = 1'b1;
        state_next = pte_pkg::ST_ELECT;
      end
      pte_pkg::ST_ELECT: begin
        if (pend && cmp.lt) begin
          cand_next = 1'b0;
        end
        if (cnt < CNT_END) begin
          pend_next = 1'b1;
          pidx_next = cnt[IW-1:0];
          cnt_next  = cnt + CNT_ONE;
        end else if (!pend) begin
          master_flag_next = cand;
          state_next       = pte_pkg::ST_FINISH;
        end else begin
          pend_next = 1'b0;
        end
      end
      pte_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {unknown, evicted, written, slot_ext[2:0],
                           master_flag ^ prev_master, master_flag};
          state_next    = pte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pte_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pte_pkg::ST_IDLE;
      cnt         <= '0;
      pend        <= 1'b0;
      master_flag <= 1'b1;
      own_light   <= 16'd0;
      own_id      <= 8'd0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pend        <= pend_next;
      master_flag <= master_flag_next;
      own_light   <= own_light_next;
      m_tvalid    <= m_tvalid_next;
      if (cfg_wr_en) begin
        own_id <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx        <= pidx_next;
    slot        <= slot_next;
    best_idx    <= best_idx_next;
    best_time   <= best_time_next;
    cand        <= cand_next;
    prev_master <= prev_master_next;
    written     <= written_next;
    evicted     <= evicted_next;
    unknown     <= unknown_next;
    m_tdata     <= m_tdata_next;
    if (s_tvalid && s_tready) begin
      sid    <= in_sid;
      slight <= in_slight;
      now    <= in_now;
    end
  end

endmodule

@@ bench/peer_table_checker.sv @@
`timescale 1ns / 1ps
module peer_table_checker
  import pte_pkg::*;
#(
  parameter int SLOTS = TABLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic [8:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          evictions,
  output int          master_flips
);

  typedef struct packed {
    logic       unknown_type;
    logic       evicted;
    logic       slot_written;
    logic [2:0] slot_index;
    logic       master_changed;
    logic       is_master;
  } election_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [9:0]  local_light;
    logic [31:0] now_ms;
    logic [15:0] sender_light;
    logic [7:0]  sender_version;
    logic [7:0]  sender_master;
    logic [7:0]  sender_id;
  } peer_word_t;

  typedef struct packed {
    logic [7:0] packet_type;
    logic       action;
  } peer_kind_t;

  logic [7:0]  node_id;
  logic [7:0]  slot_id    [SLOTS];
  logic [15:0] slot_light [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic        leader;
  election_t   election_q [$];

  function automatic election_t elect_next(peer_word_t w, peer_kind_t k);
    election_t v;
    logic      was_leader;
    logic      hit;
    int        slot;
    v = '0;
    was_leader = leader;
    hit = 1'b0;
    slot = 0;
    if (k.action == ACT_SAMPLE) begin
      slot_light[0] = {6'b0, w.local_light};
    end else begin
      case (k.packet_type)
        PKT_LIGHT_UPDATE: begin
          if (w.sender_id != node_id) begin
            for (int i = 1; i < SLOTS; i++) begin
              if (!hit && (slot_id[i] == w.sender_id || slot_id[i] == 8'd0)) begin
                slot = i;
                hit = 1'b1;
              end
            end
            // evict the oldest stamp, lowest slot on a tie; own slot is never a candidate
            if (!hit) begin
              slot = 1;
              for (int i = 2; i < SLOTS; i++) begin
                if (slot_stamp[i] < slot_stamp[slot]) slot = i;
              end
              v.evicted = 1'b1;
            end
            slot_id[slot] = w.sender_id;
          end
          slot_light[slot] = w.sender_light;
          slot_stamp[slot] = w.now_ms;
          leader = 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_light[0] < slot_light[i]) leader = 1'b0;
          end
          v.slot_written = 1'b1;
          v.slot_index = 3'(slot);
        end
        PKT_RESET_SWARM: leader = 1'b1;
        PKT_RESET_ME: begin
          if (w.sender_id == node_id) leader = 1'b1;
        end
        PKT_SERVER, PKT_BLINK, PKT_LOG: begin
        end
        default: v.unknown_type = 1'b1;
      endcase
    end
    v.is_master = leader;
    v.master_changed = (leader != was_leader);
    return v;
  endfunction

  function automatic int field_bad(string name, int want, int got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    election_t got;
    election_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      node_id = 8'd0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i] = 8'd0;
        slot_light[i] = 16'd0;
        slot_stamp[i] = 32'd0;
      end
      leader = 1'b1;
      election_q.delete();
      fail_count <= 0;
      pending <= 0;
      words_checked <= 0;
      evictions <= 0;
      master_flips <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = election_t'(m_tdata);
        if (election_q.size() == 0) begin
          $error("result word %h arrived with nothing expected", m_tdata);
          errs++;
        end else begin
          want = election_q.pop_front();
          errs += field_bad("is_master", want.is_master, got.is_master);
          errs += field_bad("master_changed", want.master_changed, got.master_changed);
          errs += field_bad("slot_index", want.slot_index, got.slot_index);
          errs += field_bad("slot_written", want.slot_written, got.slot_written);
          errs += field_bad("evicted", want.evicted, got.evicted);
          errs += field_bad("unknown_type", want.unknown_type, got.unknown_type);
        end
        words_checked <= words_checked + 1;
      end
      if (s_tvalid && s_tready) begin
        want = elect_next(peer_word_t'(s_tdata), peer_kind_t'(s_tuser));
        election_q.push_back(want);
        evictions <= evictions + want.evicted;
        master_flips <= master_flips + want.master_changed;
      end
      if (cfg_wr_en) node_id = cfg_wr_data;
      fail_count <= fail_count + errs;
      pending <= election_q.size();
    end
  end

endmodule

@@ bench/tb_peer_table_leader_election.sv @@
`timescale 1ns / 1ps
module tb_peer_table_leader_election;
  import pte_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [7:0] PKT_UNHANDLED = 8'd5;
  localparam logic [7:0] PKT_TOP = 8'd255;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // sender_id, sender_master, sender_version, sender_light, now_ms, local_light, pad
  logic [87:0] s_tdata = '0;
  // action, packet_type
  logic [8:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // is_master, master_changed, slot_index, slot_written, evicted, unknown_type
  logic [7:0]  m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  logic [7:0]  node_id = 8'd0;
  logic [31:0] stamp_clock = 32'd0;

  int          fail_count;
  int          pending;
  int          words_checked;
  int          evictions;
  int          master_flips;

  peer_table_leader_election u_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  peer_table_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .evictions     (evictions),
    .master_flips  (master_flips)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input logic act, input logic [7:0] ptype, input logic [7:0] sid,
                           input logic [7:0] smaster, input logic [7:0] sver,
                           input logic [15:0] slight, input logic [31:0] stamp,
                           input logic [9:0] llight);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, llight, stamp, slight, sver, smaster, sid};
    s_tuser <= {ptype, act};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_id = value;
  endtask

  task automatic send_random();
    logic        act;
    logic [7:0]  ptype;
    logic [7:0]  sid;
    logic [15:0] slight;
    logic [31:0] stamp;
    int          r;
    act = ($urandom_range(99) < 12) ? ACT_SAMPLE : ACT_PACKET;
    r = $urandom_range(99);
    if (r < 65) ptype = PKT_LIGHT_UPDATE;
    else if (r < 72) ptype = PKT_RESET_SWARM;
    else if (r < 80) ptype = PKT_RESET_ME;
    else if (r < 88) begin
      case ($urandom_range(2))
        0: ptype = PKT_SERVER;
        1: ptype = PKT_BLINK;
        default: ptype = PKT_LOG;
      endcase
    end else ptype = 8'($urandom_range(5, 255));
    // small id pool keeps the table full, so matches and evictions both occur
    r = $urandom_range(99);
    if (r < 55) sid = 8'($urandom_range(1, 10));
    else if (r < 70) sid = node_id;
    else if (r < 75) sid = 8'd0;
    else sid = 8'($urandom);
    slight = $urandom_range(1) ? 16'($urandom_range(1100)) : 16'($urandom);
    stamp_clock = stamp_clock + 32'($urandom_range(50));
    case ($urandom_range(3))
      0: stamp = $urandom;
      1: stamp = 32'($urandom_range(15));
      2: stamp = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      default: stamp = stamp_clock;
    endcase
    send_word(act, ptype, sid, 8'($urandom), 8'($urandom), slight, stamp, 10'($urandom));
  endtask

  task automatic run_phase(input logic [7:0] own, input int sidle, input int ridle,
                           input logic with_hold);
    wait_for_results();
    write_own_id(own);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (with_hold && n == RANDOM_PER_PHASE / 2) begin
        wait_for_results();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      send_random();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_own_id(8'hA5);

    send_word(ACT_SAMPLE, PKT_TOP, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_word(ACT_SAMPLE, PKT_LIGHT_UPDATE, 8'h00, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd1, 8'h00, 8'h00, 16'h0000, 32'hFFFF_FFFF,
              10'h3FF);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd2, 8'hFF, 8'hFF, 16'hFFFF, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd0, 8'h01, 8'h01, 16'd5, 32'd7, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd0, 8'h02, 8'h02, 16'd6, 32'd8, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'hA5, 8'hFF, 8'hFF, 16'h0000, 32'd3, 10'h000);
    send_word(ACT_SAMPLE, PKT_LIGHT_UPDATE, 8'h00, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h3FF);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd2, 8'h00, 8'h00, 16'd100, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd2, 8'h00, 8'h00, 16'hFFFF, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_RESET_SWARM, 8'h00, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'd1, 8'h00, 8'h00, 16'h0000, 32'hFFFF_FFFF,
              10'h000);
    send_word(ACT_PACKET, PKT_RESET_ME, 8'hA4, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_RESET_ME, 8'hA5, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_SERVER, 8'h11, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_BLINK, 8'h22, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_LOG, 8'h33, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_UNHANDLED, 8'h44, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    send_word(ACT_PACKET, PKT_TOP, 8'h55, 8'h00, 8'h00, 16'h0000, 32'd0, 10'h000);
    // fill the table with equal stamps, then evict twice to hit the tie
    for (int id = 3; id <= 9; id++) begin
      send_word(ACT_PACKET, PKT_LIGHT_UPDATE, 8'(id), 8'(id), 8'(id), 16'(id * 7), 32'd10,
                10'h000);
    end

    run_phase(8'hFF, 12, 81, 1'b1);
    run_phase(8'h3C, 81, 12, 1'b0);
    run_phase(8'h00, 0, 0, 1'b1);
    wait_for_results();

    $display("covered %0d result words under own ids 0xA5, 0xFF, 0x3C and 0x00",
             words_checked);
    $display("saw %0d evictions and %0d master changes, with long output holds and drains",
             evictions, master_flips);
    if (fail_count == 0) begin
      $display("peer_table_leader_election regression: pass");
    end else begin
      $display("peer_table_leader_election regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("peer_table_leader_election regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pte_pkg.sv
rtl/pte_cmp.sv
rtl/pte_table.sv
rtl/peer_table_leader_election.sv
bench/peer_table_checker.sv
bench/tb_peer_table_leader_election.sv
